/* rtl/core/permutation_order_crossover_unit_defines.svh */
// Assertion macros for the permutation order crossover unit.
`ifndef PERMUTATION_ORDER_CROSSOVER_UNIT_DEFINES_SVH
`define PERMUTATION_ORDER_CROSSOVER_UNIT_DEFINES_SVH

// Condition must never hold.
`define POCX_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent implies consequent on the next clock.
`define POCX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pocx_pkg.sv */
// Shared types and constants for the permutation order crossover unit.
package pocx_pkg;

    localparam int MAX_CITIES = 32;
    localparam int CITY_W     = 5;
    localparam int POS_W      = $clog2(MAX_CITIES);
    localparam int CNT_W      = $clog2(MAX_CITIES + 1);
    localparam int TAKEN_W    = 1 << CITY_W;
    localparam int CMP_W      = (CNT_W > CITY_W) ? CNT_W : CITY_W;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [4:0] gene_first;
        logic [4:0] gene_second;
        logic [4:0] cut_a;
        logic [4:0] cut_b;
        logic       last_gene;
    } request_t;

    typedef struct packed {
        logic [4:0] child_gene;
        logic       child_last;
        logic       bad_parents;
    } result_t;

    typedef struct packed {
        logic [CITY_W-1:0] gene_first;
        logic [CITY_W-1:0] gene_second;
        logic [CITY_W-1:0] cut_lo;
        logic [CITY_W-1:0] cut_hi;
        logic              last_gene;
    } cmd_t;

endpackage

/* rtl/core/pocx_front.sv */
// Front end: accept requests, order the cuts and queue commands.
module pocx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pocx_pkg::request_t request,
    input  logic              q_full,
    input  logic              back_done,
    output logic              busy,
    output logic              push,
    output pocx_pkg::cmd_t    cmd
);
    import pocx_pkg::*;

    logic pending_reg;
    logic pending_next;
    logic swap;

    assign busy = q_full || pending_reg;
    assign push = start && !busy;
    assign swap = request.cut_a > request.cut_b;

    always_comb
    begin
        cmd.gene_first  = request.gene_first;
        cmd.gene_second = request.gene_second;
        cmd.cut_lo      = swap ? request.cut_b : request.cut_a;
        cmd.cut_hi      = swap ? request.cut_a : request.cut_b;
        cmd.last_gene   = request.last_gene;
    end

    // Hold off new requests from the last pair until the child is out.
    always_comb
    begin
        pending_next = pending_reg;
        if (back_done)
        begin
            pending_next = 1'b0;
        end
        if (push && request.last_gene)
        begin
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

/* rtl/core/pocx_queue.sv */
// Two-entry command queue between front and back end.
module pocx_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pocx_pkg::cmd_t push_cmd,
    input  logic           pop,
    output pocx_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);
    import pocx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t                        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_reg;
    logic                        do_push;
    logic                        do_pop;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/pocx_back.sv */
// Back end: parent stores, segment marking and child generation.
module pocx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pocx_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              back_done,
    output logic              result_valid,
    output pocx_pkg::result_t result
);
    import pocx_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_EMIT_SEL,
        ST_EMIT_SEG,
        ST_EMIT_SCAN
    } state_t;

    logic [CITY_W-1:0] first_mem  [MAX_CITIES];
    logic [CITY_W-1:0] second_mem [MAX_CITIES];
    logic [CITY_W-1:0] first_q;
    logic [CITY_W-1:0] second_q;
    logic              wr_en;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   n_m1_reg, n_m1_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [TAKEN_W-1:0] taken_reg, taken_next;
    logic               bad_reg, bad_next;
    logic               valid_reg, valid_next;
    result_t            out_reg, out_next;

    logic               room;
    logic [CNT_W-1:0]   cnt_after;
    logic [POS_W-1:0]   last_pos;
    logic               in_seg;
    logic               advance;
    logic               pos_end;

    function automatic logic [POS_W-1:0] clamp_cut(
        input logic [CITY_W-1:0] cut,
        input logic [POS_W-1:0]  lim
    );
        logic [POS_W-1:0] res;
        if (CMP_W'(cut) > CMP_W'(lim))
        begin
            res = lim;
        end
        else
        begin
            res = POS_W'(cut);
        end
        return res;
    endfunction

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign room      = count_reg < CNT_W'(MAX_CITIES);
    assign wr_en     = pop && room;
    assign cnt_after = room ? count_reg + 1'b1 : count_reg;
    assign last_pos  = POS_W'(cnt_after - 1'b1);
    assign in_seg    = (pos_reg >= lo_reg) && (pos_reg <= hi_reg);
    assign pos_end   = (pos_reg == n_m1_reg);
    assign back_done = advance && pos_end;

    assign result_valid = valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            first_mem[count_reg[POS_W-1:0]]  <= head_cmd.gene_first;
            second_mem[count_reg[POS_W-1:0]] <= head_cmd.gene_second;
        end
        first_q  <= first_mem[pos_reg];
        second_q <= second_mem[scan_reg[POS_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_m1_next  = n_m1_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        scan_next  = scan_reg;
        taken_next = taken_reg;
        bad_next   = bad_reg;
        valid_next = 1'b0;
        out_next   = out_reg;
        advance    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    count_next = cnt_after;
                    if (head_cmd.last_gene)
                    begin
                        n_m1_next  = last_pos;
                        lo_next    = clamp_cut(head_cmd.cut_lo, last_pos);
                        hi_next    = clamp_cut(head_cmd.cut_hi, last_pos);
                        pos_next   = clamp_cut(head_cmd.cut_lo, last_pos);
                        taken_next = '0;
                        scan_next  = '0;
                        bad_next   = 1'b0;
                        state_next = ST_MARK_RD;
                    end
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                taken_next = taken_reg | (TAKEN_W'(1) << first_q);
                if (pos_reg == hi_reg)
                begin
                    pos_next   = '0;
                    state_next = ST_EMIT_SEL;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_MARK_RD;
                end
            end
            ST_EMIT_SEL:
            begin
                if (in_seg)
                begin
                    state_next = ST_EMIT_SEG;
                end
                else if (scan_reg == CNT_W'(n_m1_reg) + 1'b1)
                begin
                    // Second parent exhausted: emit a blank gene and flag it.
                    bad_next             = 1'b1;
                    valid_next           = 1'b1;
                    out_next.child_gene  = '0;
                    out_next.child_last  = pos_end;
                    out_next.bad_parents = 1'b1;
                    advance              = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT_SCAN;
                end
            end
            ST_EMIT_SEG:
            begin
                valid_next           = 1'b1;
                out_next.child_gene  = first_q;
                out_next.child_last  = pos_end;
                out_next.bad_parents = bad_reg;
                advance              = 1'b1;
            end
            ST_EMIT_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (taken_reg[second_q])
                begin
                    state_next = ST_EMIT_SEL;
                end
                else
                begin
                    taken_next           = taken_reg | (TAKEN_W'(1) << second_q);
                    valid_next           = 1'b1;
                    out_next.child_gene  = second_q;
                    out_next.child_last  = pos_end;
                    out_next.bad_parents = bad_reg;
                    advance              = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            if (pos_end)
            begin
                count_next = '0;
                taken_next = '0;
                scan_next  = '0;
                state_next = ST_IDLE;
            end
            else
            begin
                pos_next   = pos_reg + 1'b1;
                state_next = ST_EMIT_SEL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            n_m1_reg  <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            pos_reg   <= '0;
            scan_reg  <= '0;
            taken_reg <= '0;
            bad_reg   <= 1'b0;
            valid_reg <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_m1_reg  <= n_m1_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            pos_reg   <= pos_next;
            scan_reg  <= scan_next;
            taken_reg <= taken_next;
            bad_reg   <= bad_next;
            valid_reg <= valid_next;
            out_reg   <= out_next;
        end
    end

endmodule

/* rtl/core/permutation_order_crossover_unit.sv */
// Top level of the permutation order crossover unit.
// Each request loads one gene pair of the two parent tours; a two-entry queue
// lets the parent stores absorb pairs one per cycle. The request marked
// last_gene starts the crossover and busy stays high until the final child
// gene is on result: each gene between the cuts is read in ST_MARK_RD and
// marked in ST_MARK_WR; each child position takes ST_EMIT_SEL then ST_EMIT_SEG
// or ST_EMIT_SCAN, and each already-taken second-parent gene skipped adds
// ST_EMIT_SCAN and ST_EMIT_SEL, all set by the single read port of each parent
// store; a position left blank once the second parent has run out is emitted
// from ST_EMIT_SEL. Results appear on result with result_valid high for exactly
// one cycle each and must be captured then; the receiver cannot stall the unit.
module permutation_order_crossover_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pocx_pkg::request_t request,
    output logic              result_valid,
    output pocx_pkg::result_t result
);
    import pocx_pkg::*;

    `include "permutation_order_crossover_unit_defines.svh"

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    logic back_done;

    pocx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .q_full    (q_full),
        .back_done (back_done),
        .busy      (busy),
        .push      (push),
        .cmd       (push_cmd)
    );

    pocx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    pocx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .back_done    (back_done),
        .result_valid (result_valid),
        .result       (result)
    );

    `POCX_ASSERT_NEVER(a_result_while_open, result_valid && !busy && !result.child_last, "result while requests open")
    `POCX_ASSERT_NEVER(a_push_when_full, push && q_full, "command pushed into full queue")
    `POCX_ASSERT_NEXT(a_gap_after_last, result_valid && result.child_last, !result_valid, "result after final child gene")

endmodule
